FILE: design/bale_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bale_pkg;

  localparam int MODE_W     = 4;
  localparam int POS_W      = 9;
  localparam int POS_END_W  = 8;
  localparam int WORD_W     = 32;
  localparam int LEN_W      = 9;
  localparam int STATUS_W   = 2;

  localparam int ADDR_MAX_W = 16;
  localparam int WORD_MAX_W = 64;

  localparam logic [MODE_W-1:0] MODE_READ     = 4'd0;
  localparam logic [MODE_W-1:0] MODE_WRITE    = 4'd1;
  localparam logic [MODE_W-1:0] MODE_APPEND   = 4'd2;
  localparam logic [MODE_W-1:0] MODE_REM_LAST = 4'd3;
  localparam logic [MODE_W-1:0] MODE_INSERT   = 4'd4;
  localparam logic [MODE_W-1:0] MODE_ERASE1   = 4'd5;
  localparam logic [MODE_W-1:0] MODE_ERASE_RG = 4'd6;
  localparam logic [MODE_W-1:0] MODE_RESIZE   = 4'd7;
  localparam logic [MODE_W-1:0] MODE_CLEAR    = 4'd8;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

  typedef logic [ADDR_MAX_W-1:0] addr_t;
  typedef logic [WORD_MAX_W-1:0] mword_t;

  typedef struct packed {
    logic   we;
    addr_t  waddr;
    mword_t wdata;
    logic   re;
    addr_t  raddr;
  } mem_req_t;

endpackage

`default_nettype wire

FILE: design/bale_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface bale_req_if;
  import bale_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [MODE_W-1:0]    mode;
  logic [POS_W-1:0]     position;
  logic [POS_END_W-1:0] position_end;
  logic [WORD_W-1:0]    value;
  logic [LEN_W-1:0]     new_length;

  modport source (output valid, mode, position, position_end, value, new_length,
                  input ready);
  modport sink   (input valid, mode, position, position_end, value, new_length,
                  output ready);
endinterface

interface bale_rsp_if;
  import bale_pkg::*;

  logic                valid;
  logic                ready;
  logic [WORD_W-1:0]   read_value;
  logic [STATUS_W-1:0] status;
  logic [LEN_W-1:0]    length;
  logic                is_empty;

  modport source (output valid, read_value, status, length, is_empty, input ready);
  modport sink   (input valid, read_value, status, length, is_empty, output ready);
endinterface

`default_nettype wire

FILE: design/bale_store.sv
`timescale 1ns / 1ps
`default_nettype none

module bale_store #(
  parameter int CAPACITY   = 256,
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  bale_pkg::mem_req_t    mreq,
  output logic [DATA_WIDTH-1:0] rdata
);
  import bale_pkg::*;

  localparam int AW = $clog2(CAPACITY);

  logic [DATA_WIDTH-1:0] mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (mreq.we) begin
      mem[mreq.waddr[AW-1:0]] <= mreq.wdata[DATA_WIDTH-1:0];
    end
    if (mreq.re) begin
      rdata <= mem[mreq.raddr[AW-1:0]];
    end
  end

endmodule

`default_nettype wire

FILE: design/bale_seq.sv
`timescale 1ns / 1ps
`default_nettype none

module bale_seq #(
  parameter int CAPACITY   = 256,
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  bale_req_if.sink              req,
  bale_rsp_if.source            rsp,
  output bale_pkg::mem_req_t    mreq,
  input  logic [DATA_WIDTH-1:0] rdata
);
  import bale_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [31:0] CAP32 = 32'(CAPACITY);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SHUP = 3'd1;
  localparam logic [2:0] S_SHDN = 3'd2;
  localparam logic [2:0] S_FILL = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]          state, state_next;
  logic [CW-1:0]       count, count_next;
  logic [CW-1:0]       cur, cur_next;
  logic [CW-1:0]       dst, dst_next;
  logic [CW-1:0]       lim, lim_next;
  logic [CW-1:0]       wdst, wdst_next;
  logic                wpend, wpend_next;
  logic [WORD_W-1:0]   val_hold, val_hold_next;
  logic [STATUS_W-1:0] st_hold, st_hold_next;
  logic                rd_sel, rd_sel_next;
  logic                out_valid, out_valid_next;
  logic [WORD_W-1:0]   out_rd, out_rd_next;
  logic [STATUS_W-1:0] out_st, out_st_next;
  logic [LEN_W-1:0]    out_len, out_len_next;
  logic                out_empty, out_empty_next;

  logic [31:0] cnt32, pos32, pend32, nlen32, cur32;
  logic [31:0] cnt_inc, cnt_dec, pos_inc, pend_inc, erase_cnt, cur_inc, cur_dec, dst_inc;
  logic [63:0] rdata64;
  logic        accept, load;

  assign cnt32     = 32'(count);
  assign pos32     = 32'(req.position);
  assign pend32    = 32'(req.position_end);
  assign nlen32    = 32'(req.new_length);
  assign cur32     = 32'(cur);
  assign cnt_inc   = cnt32 + 32'd1;
  assign cnt_dec   = cnt32 - 32'd1;
  assign pos_inc   = pos32 + 32'd1;
  assign pend_inc  = pend32 + 32'd1;
  assign erase_cnt = cnt32 - (pend32 - pos32 + 32'd1);
  assign cur_inc   = cur32 + 32'd1;
  assign cur_dec   = cur32 - 32'd1;
  assign dst_inc   = 32'(dst) + 32'd1;
  assign rdata64   = 64'(rdata);

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign load      = (state == S_FIN) && (!out_valid || rsp.ready);

  assign rsp.valid      = out_valid;
  assign rsp.read_value = out_rd;
  assign rsp.status     = out_st;
  assign rsp.length     = out_len;
  assign rsp.is_empty   = out_empty;

  always_comb begin
    state_next     = state;
    count_next     = count;
    cur_next       = cur;
    dst_next       = dst;
    lim_next       = lim;
    wdst_next      = wdst;
    wpend_next     = wpend;
    val_hold_next  = val_hold;
    st_hold_next   = st_hold;
    rd_sel_next    = rd_sel;
    out_valid_next = out_valid;
    out_rd_next    = out_rd;
    out_st_next    = out_st;
    out_len_next   = out_len;
    out_empty_next = out_empty;
    mreq           = '0;

    case (state)
      S_IDLE: begin
        if (accept) begin
          st_hold_next = ST_OK;
          rd_sel_next  = 1'b0;
          state_next   = S_FIN;
          case (req.mode)
            MODE_READ: begin
              if (pos32 < cnt32) begin
                mreq.re     = 1'b1;
                mreq.raddr  = addr_t'(req.position);
                rd_sel_next = 1'b1;
              end else begin
                st_hold_next = ST_RANGE;
              end
            end
            MODE_WRITE: begin
              if (pos32 < cnt32) begin
                mreq.we    = 1'b1;
                mreq.waddr = addr_t'(req.position);
                mreq.wdata = mword_t'(req.value);
              end else begin
                st_hold_next = ST_RANGE;
              end
            end
            MODE_APPEND: begin
              if (cnt32 >= CAP32) begin
                st_hold_next = ST_FULL;
              end else begin
                mreq.we    = 1'b1;
                mreq.waddr = addr_t'(count);
                mreq.wdata = mword_t'(req.value);
                count_next = cnt_inc[CW-1:0];
              end
            end
            MODE_REM_LAST: begin
              if (cnt32 == 32'd0) begin
                st_hold_next = ST_EMPTY;
              end else begin
                mreq.re     = 1'b1;
                mreq.raddr  = addr_t'(cnt_dec);
                count_next  = cnt_dec[CW-1:0];
                rd_sel_next = 1'b1;
              end
            end
            MODE_INSERT: begin
              if (pos32 > cnt32) begin
                st_hold_next = ST_RANGE;
              end else if (cnt32 >= CAP32) begin
                st_hold_next = ST_FULL;
              end else begin
                cur_next      = count;
                lim_next      = pos32[CW-1:0];
                wpend_next    = 1'b0;
                val_hold_next = req.value;
                state_next    = S_SHUP;
              end
            end
            MODE_ERASE1: begin
              if (pos32 >= cnt32) begin
                st_hold_next = ST_RANGE;
              end else begin
                cur_next   = pos_inc[CW-1:0];
                dst_next   = pos32[CW-1:0];
                lim_next   = cnt_dec[CW-1:0];
                wpend_next = 1'b0;
                state_next = S_SHDN;
              end
            end
            MODE_ERASE_RG: begin
              if (pos32 > pend32 || pend32 >= cnt32) begin
                st_hold_next = ST_RANGE;
              end else begin
                cur_next   = pend_inc[CW-1:0];
                dst_next   = pos32[CW-1:0];
                lim_next   = erase_cnt[CW-1:0];
                wpend_next = 1'b0;
                state_next = S_SHDN;
              end
            end
            MODE_RESIZE: begin
              if (nlen32 > CAP32) begin
                st_hold_next = ST_FULL;
              end else if (nlen32 > cnt32) begin
                cur_next   = count;
                lim_next   = nlen32[CW-1:0];
                state_next = S_FILL;
              end else begin
                count_next = nlen32[CW-1:0];
              end
            end
            MODE_CLEAR: begin
              count_next = '0;
            end
            default: begin
            end
          endcase
        end
      end

      S_SHUP: begin
        if (wpend) begin
          mreq.we    = 1'b1;
          mreq.waddr = addr_t'(wdst);
          mreq.wdata = rdata64;
        end
        if (cur > lim) begin
          mreq.re    = 1'b1;
          mreq.raddr = addr_t'(cur_dec);
          wdst_next  = cur;
          wpend_next = 1'b1;
          cur_next   = cur_dec[CW-1:0];
        end else begin
          wpend_next = 1'b0;
          if (!wpend) begin
            mreq.we    = 1'b1;
            mreq.waddr = addr_t'(lim);
            mreq.wdata = mword_t'(val_hold);
            count_next = cnt_inc[CW-1:0];
            state_next = S_FIN;
          end
        end
      end

      S_SHDN: begin
        if (wpend) begin
          mreq.we    = 1'b1;
          mreq.waddr = addr_t'(wdst);
          mreq.wdata = rdata64;
        end
        if (cur < count) begin
          mreq.re    = 1'b1;
          mreq.raddr = addr_t'(cur);
          wdst_next  = dst;
          dst_next   = dst_inc[CW-1:0];
          cur_next   = cur_inc[CW-1:0];
          wpend_next = 1'b1;
        end else begin
          wpend_next = 1'b0;
          if (!wpend) begin
            count_next = lim;
            state_next = S_FIN;
          end
        end
      end

      S_FILL: begin
        mreq.we    = 1'b1;
        mreq.waddr = addr_t'(cur);
        mreq.wdata = '0;
        cur_next   = cur_inc[CW-1:0];
        if (cur_inc[CW-1:0] == lim) begin
          count_next = lim;
          state_next = S_FIN;
        end
      end

      S_FIN: begin
        if (load) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (load) begin
      out_valid_next = 1'b1;
      out_rd_next    = rd_sel ? rdata64[WORD_W-1:0] : '0;
      out_st_next    = st_hold;
      out_len_next   = cnt32[LEN_W-1:0];
      out_empty_next = (count == '0);
    end else if (rsp.ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      wpend     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      wpend     <= wpend_next;
      out_valid <= out_valid_next;
    end
    cur       <= cur_next;
    dst       <= dst_next;
    lim       <= lim_next;
    wdst      <= wdst_next;
    val_hold  <= val_hold_next;
    st_hold   <= st_hold_next;
    rd_sel    <= rd_sel_next;
    out_rd    <= out_rd_next;
    out_st    <= out_st_next;
    out_len   <= out_len_next;
    out_empty <= out_empty_next;
  end

endmodule

`default_nettype wire

FILE: design/bounded_array_list_engine_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Fields
// req      in   mode, position, position_end, value, new_length
// rsp      out  read_value, status, length, is_empty
//
// One request is taken at a time; a result then waits in the output register.
// Read, write, append, remove last, clear, shrink and refused requests need no shifting.
// Insert moves the elements from position up by one place, then writes value at position;
// erase one and erase range move the later elements down; grow by resize writes zeros.
// Each move reads and then writes through the single store write port.
// Synchronous reset empties the list; the store keeps its contents.
// A stalled rsp holds the result, and the next request finishes when it is taken.

module bounded_array_list_engine_top #(
  parameter int CAPACITY   = 256,
  parameter int DATA_WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst,
  bale_req_if.sink   req,
  bale_rsp_if.source rsp
);
  import bale_pkg::*;

  mem_req_t              mreq;
  logic [DATA_WIDTH-1:0] rdata;

  bale_seq #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_seq (
    .clk   (clk),
    .rst   (rst),
    .req   (req),
    .rsp   (rsp),
    .mreq  (mreq),
    .rdata (rdata)
  );

  bale_store #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_store (
    .clk   (clk),
    .mreq  (mreq),
    .rdata (rdata)
  );

endmodule

`default_nettype wire
